>>> sv/adnp_pkg.sv
package adnp_pkg;

  // Channel field types
  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  // Command codes; the unused code behaves as CMD_NEXT
  localparam cmd_t CMD_NEXT = 2'd0;
  localparam cmd_t CMD_INT  = 2'd1;
  localparam cmd_t CMD_DEC  = 2'd2;

  // Result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NO_DIGIT = 2'd1;
  localparam status_t ST_NO_FRAC  = 2'd2;
  localparam status_t ST_TOO_MANY = 2'd3;

  // Characters of interest
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_FRACTION_DIGITS_DEF = 10;
  localparam int unsigned FRACTION_BITS_DEF       = 32;

  // Fixed widths: result, integer part, fraction remainder (below 10^10)
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned INT_W   = 31;
  localparam int unsigned REM_W   = 34;

  // Powers of ten up to 10^10; other codes read as zero
  function automatic logic [REM_W-1:0] pow10(input logic [3:0] k);
    logic [REM_W-1:0] p;
    case (k)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      4'd10:   p = 34'd10000000000;
      default: p = 34'd0;
    endcase
    return p;
  endfunction

endpackage

>>> sv/ascii_decimal_number_parser_unit.sv
// ASCII number parser: takes one character per transfer and converts integer or decimal text
// to a binary value. The input takes a transfer every clock cycle while the result register
// is empty or being drained; in_stall rises only while an unclaimed result sits in the output
// register and out_stall is high. The result of a terminating character is registered and presented in
// the cycle after its transfer. Decimal fractions are converted exactly as the digits arrive: each digit
// adds its weight d * 2^FRACTION_BITS / 10^position from a constant quotient/remainder table,
// with a single compare-and-subtract on the running remainder, so a number ends with only a
// round, a saturate and a negate. Decimal results are two's complement with FRACTION_BITS
// fraction bits, rounded half up; integer parts saturate at 2^31-1.
module ascii_decimal_number_parser_unit #(
  parameter int unsigned MAX_FRACTION_DIGITS = adnp_pkg::MAX_FRACTION_DIGITS_DEF,
  parameter int unsigned FRACTION_BITS       = adnp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  adnp_pkg::cmd_t                      in_command,
  input  logic [7:0]                          in_character,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [adnp_pkg::VALUE_W-1:0] out_value,
  output adnp_pkg::status_t                   out_status
);
  import adnp_pkg::*;

  localparam int unsigned FB     = FRACTION_BITS;
  localparam int unsigned CNT_W  = $clog2(MAX_FRACTION_DIGITS + 2);
  localparam int unsigned ROWS   = 2 ** CNT_W;
  localparam int unsigned ACC_W  = REM_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FRACTION_DIGITS);
  localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_FRACTION_DIGITS + 1);
  localparam logic [ACC_W-1:0] INT_SAT  = ACC_W'(32'h7FFF_FFFF);
  localparam logic [VALUE_W-1:0] MAG_SAT = {1'b0, {(VALUE_W-1){1'b1}}};

  // Parser phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_INT   = 3'd1;
  localparam logic [2:0] PH_SIGN  = 3'd2;
  localparam logic [2:0] PH_DINT  = 3'd3;
  localparam logic [2:0] PH_POINT = 3'd4;
  localparam logic [2:0] PH_FRAC  = 3'd5;

  // Digit weight table: row = digits already taken, column = digit value
  logic [FB-1:0]    tab_q [ROWS][16];
  logic [REM_W-1:0] tab_r [ROWS][16];

  for (genvar gp = 0; gp < ROWS; gp++) begin : g_row
    for (genvar gd = 0; gd < 16; gd++) begin : g_col
      localparam int unsigned J = (gp < MAX_FRACTION_DIGITS) ? gp + 1 : 1;
      localparam logic [63:0] NUM = (gd < 10 && gp < MAX_FRACTION_DIGITS) ?
                                    (64'(gd) << FB) : 64'd0;
      localparam logic [63:0] DIV = 64'(pow10(4'(J)));
      localparam logic [63:0] QV  = NUM / DIV;
      localparam logic [63:0] RV  = NUM % DIV;
      assign tab_q[gp][gd] = FB'(QV);
      assign tab_r[gp][gd] = REM_W'(RV);
    end
  end

  // State
  logic [2:0]         phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [INT_W-1:0]   int_r, int_nxt;
  logic [FB-1:0]      q_r, q_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  status_t            out_status_r, out_status_nxt;

  logic               in_xfer;
  logic               start;
  logic               is_digit;
  logic [3:0]         digit;
  logic [ACC_W-1:0]   int_sum;
  logic [INT_W-1:0]   int_sat;
  logic [ACC_W-1:0]   frac_sum;
  logic [ACC_W-1:0]   frac_thr;
  logic               frac_carry;
  logic               round_up;
  logic [VALUE_W-1:0] mag;
  logic [VALUE_W-1:0] mag_sat;
  logic [VALUE_W-1:0] dec_value;
  logic               emit;
  logic [VALUE_W-1:0] emit_value;
  status_t            emit_status;

  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign start    = (in_command == CMD_INT) || (in_command == CMD_DEC);
  assign is_digit = in_character inside {[CH_ZERO:CH_NINE]};
  assign digit    = in_character[3:0];

  // Integer digit: times ten plus digit, saturating
  assign int_sum = ({int_r, 3'b000} + {3'b000, int_r, 1'b0}) + ACC_W'(digit);
  assign int_sat = (int_sum > INT_SAT) ? INT_W'(INT_SAT) : INT_W'(int_sum);

  // Fraction digit: add the table weight, fold the remainder back below 10^(k+1)
  assign frac_sum   = ({rem_r, 1'b0} + {rem_r[ACC_W-4:0], 3'b000}) +
                      ACC_W'(tab_r[cnt_r][digit]);
  assign frac_thr   = ACC_W'(pow10(4'(cnt_r) + 4'd1));
  assign frac_carry = frac_sum >= frac_thr;

  // Decimal result: round half up, saturate the magnitude, apply the sign
  assign round_up  = (cnt_r != '0) && ({rem_r, 1'b0} >= ACC_W'(pow10(4'(cnt_r))));
  assign mag       = VALUE_W'({int_r, q_r}) + VALUE_W'(round_up);
  assign mag_sat   = mag[VALUE_W-1] ? MAG_SAT : mag;
  assign dec_value = neg_r ? (~mag_sat + VALUE_W'(1)) : mag_sat;

  // Next state for one character transfer
  always_comb begin
    phase_nxt   = phase_r;
    neg_nxt     = neg_r;
    int_nxt     = int_r;
    q_nxt       = q_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    emit        = 1'b0;
    emit_value  = '0;
    emit_status = ST_OK;
    if (start) begin
      neg_nxt = 1'b0;
      int_nxt = '0;
      q_nxt   = '0;
      rem_nxt = '0;
      cnt_nxt = '0;
      if (is_digit) begin
        int_nxt   = INT_W'(digit);
        phase_nxt = (in_command == CMD_DEC) ? PH_DINT : PH_INT;
      end else if ((in_command == CMD_DEC) && (in_character == CH_MINUS)) begin
        neg_nxt   = 1'b1;
        phase_nxt = PH_SIGN;
      end else begin
        emit        = 1'b1;
        emit_status = ST_NO_DIGIT;
        phase_nxt   = PH_IDLE;
      end
    end else begin
      case (phase_r)
        PH_INT: begin
          if (is_digit) begin
            int_nxt = int_sat;
          end else begin
            emit       = 1'b1;
            emit_value = VALUE_W'(int_r);
            phase_nxt  = PH_IDLE;
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            int_nxt   = int_sat;
            phase_nxt = PH_DINT;
          end else begin
            emit        = 1'b1;
            emit_status = ST_NO_DIGIT;
            phase_nxt   = PH_IDLE;
          end
        end
        PH_DINT: begin
          if (is_digit) begin
            int_nxt = int_sat;
          end else if (in_character == CH_POINT) begin
            phase_nxt = PH_POINT;
          end else begin
            emit       = 1'b1;
            emit_value = dec_value;
            phase_nxt  = PH_IDLE;
          end
        end
        PH_POINT, PH_FRAC: begin
          if (is_digit) begin
            if (cnt_r < CNT_MAX) begin
              q_nxt   = q_r + tab_q[cnt_r][digit] + FB'(frac_carry);
              rem_nxt = frac_carry ? REM_W'(frac_sum - frac_thr) : REM_W'(frac_sum);
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              cnt_nxt = CNT_OVER;
            end
            phase_nxt = PH_FRAC;
          end else begin
            emit      = 1'b1;
            phase_nxt = PH_IDLE;
            if (phase_r == PH_POINT) begin
              emit_status = ST_NO_FRAC;
            end else if (cnt_r > CNT_MAX) begin
              emit_status = ST_TOO_MANY;
            end else begin
              emit_value = dec_value;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Load a new result, drop the current one once transferred
  always_comb begin
    out_valid_nxt  = out_valid_r & out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (in_xfer && emit) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = emit_value;
      out_status_nxt = emit_status;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r <= phase_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Accumulators and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      neg_r <= neg_nxt;
      int_r <= int_nxt;
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with an empty result register");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && emit) |=> (out_valid_r && out_status_r == $past(emit_status)))
    else $error("terminating character did not load a result");

  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_value_r == '0))
    else $error("error result carries a nonzero value");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FRAC) |-> (cnt_r != '0 && cnt_r <= CNT_OVER))
    else $error("fraction digit count out of range");
`endif

endmodule
